### rtl/core/tmh_pkg.sv
// shared constants and types for the timer min-heap
package tmh_pkg;
  localparam int MAX_ENTRIES = 256;
  localparam int TIME_BITS   = 64;
  localparam int ID_W        = 8;
  localparam int ID_SPACE    = 1 << ID_W;
  localparam int CAPACITY    = (MAX_ENTRIES < ID_SPACE) ? MAX_ENTRIES : ID_SPACE;
  localparam int SLOT_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int CMP_W       = SLOT_W + 2;
  localparam int ENTRY_W     = ID_W + TIME_BITS;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_ABS  = 2'd2;
  localparam status_t ST_DUP  = 2'd3;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]             id;
    logic signed [TIME_BITS-1:0] t;
  } entry_t;
endpackage

### rtl/core/tmh_ram.sv
// generic one-write one-read ram with registered read data
module tmh_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/timer_min_heap.sv
// timer min-heap top level: sequencer, position map and slot memory
//
// Binary min-heap of timer entries keyed by signed expiry time, with removal
// by id. Each request is an insert or a remove and answers one result with the
// new top entry, the entry count and a status (ok, full, id absent, id
// duplicate). The block takes one request at a time; in_tready is high only
// while the sequencer is idle. An insert rises level by level from the next
// free slot; a remove sifts the last entry up from the freed slot, or down
// when it cannot rise. A result that waits on out_tready holds the
// sequencer. The sequence is paced by the single read port of the slot
// memory and the single compare unit: each heap level needs one read (two
// when comparing both children) before the compare. The moving entry stays
// in registers and is written once at its final slot. The top entry is
// mirrored in registers. No clearing pass is needed after reset.
module timer_min_heap (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // entry_id [7:0], expiry_time [71:8]
  input  logic [71:0]  in_tdata,
  // command
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // earliest_changed [0], top_valid [1], top_id [9:2], top_time [73:10],
  // entry_count [82:74], status [84:83], zero fill [87:85]
  output logic [87:0]  out_tdata
);
  import tmh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RM_POS, S_RM_LAST, S_UP_CMP, S_DN_L, S_DN_R, S_DN_PICK, S_WRITE, S_FIN
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [ID_SPACE-1:0]   present_r, present_nxt;
  entry_t                mv_r, mv_nxt;
  entry_t                lch_r, lch_nxt;
  logic [SLOT_W-1:0]     k_r, k_nxt;
  logic                  first_r, first_nxt;
  logic                  no_r_r, no_r_nxt;
  logic                  lmv_r, lmv_nxt;
  logic                  cmd_r, cmd_nxt;
  logic                  chg_r, chg_nxt;
  status_t               stat_r, stat_nxt;
  entry_t                top_r, top_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [87:0]           out_data_r, out_data_nxt;

  // memory ports
  logic                  slot_we, pos_we;
  logic [SLOT_W-1:0]     slot_waddr, slot_raddr, pos_wdata, pos_rdata;
  entry_t                slot_wdata, slot_rdata;
  logic [ID_W-1:0]       pos_waddr, pos_raddr;

  tmh_ram #(.W(ENTRY_W), .D(CAPACITY)) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  tmh_ram #(.W(SLOT_W), .D(ID_SPACE)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  // request fields
  logic [ID_W-1:0]             req_id;
  logic signed [TIME_BITS-1:0] req_time;
  assign req_id   = in_tdata[ID_W-1:0];
  assign req_time = in_tdata[ID_W +: TIME_BITS];

  // index helpers
  logic [SLOT_W-1:0] parent_k;
  logic [CMP_W-1:0]  left_k, right_k, count_x, k_x;
  assign parent_k = (k_r - SLOT_W'(1)) >> 1;
  assign k_x      = CMP_W'(k_r);
  assign left_k   = (k_x << 1) + CMP_W'(1);
  assign right_k  = left_k + CMP_W'(1);
  assign count_x  = CMP_W'(count_r);

  // shared compare unit: a strictly earlier than b
  entry_t cmp_a, cmp_b;
  logic   cmp_lt;
  assign cmp_lt = cmp_a.t < cmp_b.t;

  entry_t pick;
  logic [SLOT_W-1:0] pick_k;
  logic   dn_swap;

  assign in_tready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    present_nxt = present_r;
    mv_nxt      = mv_r;
    lch_nxt     = lch_r;
    k_nxt       = k_r;
    first_nxt   = first_r;
    no_r_nxt    = no_r_r;
    lmv_nxt     = lmv_r;
    cmd_nxt     = cmd_r;
    chg_nxt     = chg_r;
    stat_nxt    = stat_r;
    top_nxt     = top_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    slot_we     = 1'b0;
    slot_waddr  = k_r;
    slot_wdata  = mv_r;
    slot_raddr  = parent_k;
    pos_we      = 1'b0;
    pos_waddr   = mv_r.id;
    pos_wdata   = k_r;
    pos_raddr   = req_id;
    cmp_a       = mv_r;
    cmp_b       = slot_rdata;
    pick        = slot_rdata;
    pick_k      = SLOT_W'(right_k);
    dn_swap     = 1'b0;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tuser;
          chg_nxt   = 1'b0;
          stat_nxt  = ST_OK;
          first_nxt = 1'b0;
          state_nxt = S_FIN;
          if (in_tuser == CMD_INSERT) begin
            if (count_r >= CNT_W'(CAPACITY)) begin
              stat_nxt = ST_FULL;
            end else if (present_r[req_id]) begin
              stat_nxt = ST_DUP;
            end else begin
              mv_nxt = '{id: req_id, t: req_time};
              k_nxt  = SLOT_W'(count_r);
              present_nxt[req_id] = 1'b1;
              count_nxt = count_r + CNT_W'(1);
              slot_raddr = (SLOT_W'(count_r) - SLOT_W'(1)) >> 1;
              state_nxt = (count_r == '0) ? S_WRITE : S_UP_CMP;
            end
          end else begin
            if (!present_r[req_id] || count_r == '0) begin
              stat_nxt = ST_ABS;
            end else begin
              present_nxt[req_id] = 1'b0;
              count_nxt = count_r - CNT_W'(1);
              state_nxt = S_RM_POS;
            end
          end
        end
      end
      S_RM_POS: begin
        slot_raddr = SLOT_W'(count_r);
        k_nxt = pos_rdata;
        if (count_r == '0) begin
          chg_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else if (CNT_W'(pos_rdata) == count_r) begin
          state_nxt = S_FIN;
        end else begin
          chg_nxt   = (pos_rdata == '0);
          state_nxt = S_RM_LAST;
        end
      end
      S_RM_LAST: begin
        mv_nxt = slot_rdata;
        if (k_r != '0) begin
          first_nxt = 1'b1;
          state_nxt = S_UP_CMP;
        end else begin
          state_nxt = S_DN_L;
        end
      end
      S_UP_CMP: begin
        // parent data in slot_rdata
        slot_raddr = (parent_k - SLOT_W'(1)) >> 1;
        if (cmp_lt) begin
          slot_we    = 1'b1;
          slot_wdata = slot_rdata;
          pos_we     = 1'b1;
          pos_waddr  = slot_rdata.id;
          k_nxt     = parent_k;
          first_nxt = 1'b0;
          state_nxt = (parent_k == '0) ? S_WRITE : S_UP_CMP;
        end else begin
          state_nxt = first_r ? S_DN_L : S_WRITE;
        end
      end
      S_DN_L: begin
        slot_raddr = SLOT_W'(left_k);
        state_nxt  = (left_k >= count_x) ? S_WRITE : S_DN_R;
      end
      S_DN_R: begin
        // left child in slot_rdata, compared against the moving entry
        lch_nxt    = slot_rdata;
        cmp_a      = slot_rdata;
        cmp_b      = mv_r;
        lmv_nxt    = cmp_lt;
        slot_raddr = SLOT_W'(right_k);
        no_r_nxt   = (right_k >= count_x);
        state_nxt  = S_DN_PICK;
      end
      S_DN_PICK: begin
        // right child in slot_rdata, left in lch_r
        if (lmv_r) begin
          // left is earlier than the moving entry, so some child moves up
          cmp_a = lch_r;
          cmp_b = slot_rdata;
          if (no_r_r || cmp_lt) begin
            pick   = lch_r;
            pick_k = SLOT_W'(left_k);
          end
          dn_swap = 1'b1;
        end else begin
          // only a right child earlier than the moving entry can move up
          cmp_a   = slot_rdata;
          cmp_b   = mv_r;
          dn_swap = !no_r_r && cmp_lt;
        end
        if (dn_swap) begin
          slot_we    = 1'b1;
          slot_wdata = pick;
          pos_we     = 1'b1;
          pos_waddr  = pick.id;
          if (k_r == '0) top_nxt = pick;
          k_nxt     = pick_k;
          state_nxt = S_DN_L;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        slot_we = 1'b1;
        pos_we  = 1'b1;
        if (k_r == '0) begin
          top_nxt = mv_r;
          if (cmd_r == CMD_INSERT) chg_nxt = 1'b1;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[0]     = chg_r;
          out_data_nxt[1]     = (count_r != '0);
          out_data_nxt[9:2]   = (count_r != '0) ? top_r.id : '0;
          out_data_nxt[73:10] = (count_r != '0) ? 64'(top_r.t) : '0;
          out_data_nxt[82:74] = 9'(count_r);
          out_data_nxt[84:83] = stat_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mv_r       <= mv_nxt;
    lch_r      <= lch_nxt;
    k_r        <= k_nxt;
    first_r    <= first_nxt;
    no_r_r     <= no_r_nxt;
    lmv_r      <= lmv_nxt;
    cmd_r      <= cmd_nxt;
    chg_r      <= chg_nxt;
    stat_r     <= stat_nxt;
    top_r      <= top_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // count never passes capacity and tracks the presence flags
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY)) else $error("entry count above capacity");
  a_count_flags: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> $countones(present_r) == int'(count_r))
    else $error("entry count differs from presence flags");
  a_err_nochg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[84:83] != ST_OK |-> !out_tdata[0])
    else $error("error result flags a top change");
  a_top_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1] == (out_tdata[82:74] != 9'd0))
    else $error("top_valid disagrees with entry count");
endmodule
